// ----- design/stq_pkg.sv -----
`default_nettype none
package stq_pkg;
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STOP  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] EV_ACK     = 2'd0;
    localparam logic [1:0] EV_EXPIRED = 2'd1;
    localparam logic [1:0] EV_SUMMARY = 2'd2;
    localparam logic [1:0] ACT_RESCHED = 2'd0;
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_ONESHOT  = 2'd2;
    localparam logic [1:0] REG_CLOCK_MODE   = 2'd0;
    localparam logic [1:0] REG_PERIODIC_LEN = 2'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  timer_id;
        logic [63:0] length;
        logic [1:0]  action;
    } stq_in_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic        status;
        logic [3:0]  timer_id_res;
        logic [1:0]  expired_action;
        logic        resched;
        logic        prog_valid;
        logic [63:0] prog_len;
        logic        last;
    } stq_out_t;

    // One queue entry as it moves between cells.
    typedef struct packed {
        logic        valid;
        logic [3:0]  id;
        logic [63:0] rem;
        logic [1:0]  action;
    } stq_entry_t;

    // Broadcast command from the sequencer to every cell.
    typedef struct packed {
        logic        insert;   // insert key entry in sorted place
        logic        remove;   // drop first entry matching id, close gap
        logic        sub;      // subtract tick length from every entry
        logic        pop;      // shift queue toward head by one
        logic [3:0]  id;
        logic [63:0] len;
        logic [1:0]  action;
    } stq_cmd_t;
endpackage
`default_nettype wire

// ----- design/sorted_timer_expiry_queue_top.sv -----
`default_nettype none
// Sorted timer expiry queue: a row of NUM_TIMERS cells kept in ascending order
// of remaining time, with a sequencer that issues at most one row-wide command a cycle.
// Requests: raise start with req; one is taken when start is high and busy low.
// Results appear on res for one cycle each, marked by res_valid; the final one
// of a request has last set. The receiver cannot stall and need not.
// Steps of each request: a start removes, inserts and acknowledges; a
// rejected start only acknowledges; a stop acknowledges while it removes; a
// tick subtracts, pops each expired timer, makes one final check and gives
// the summary. An unused operation code is taken and leaves the block idle.
// Each result shows in the cycle after the one that forms it: a stop's
// acknowledge shows while busy is high, while the final result of a start or
// a tick shows in the first cycle with busy low, when a new request may
// already be taken.
// Configuration: cfg_we, cfg_index, cfg_data write clock_mode (0) and
// periodic_len (1) at once; in periodic mode the tick length follows
// periodic_len. Reset empties the queue and clears the registers and the
// tick length.
module sorted_timer_expiry_queue_top
    import stq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire stq_in_t     req,
    output logic             busy,
    output logic             res_valid,
    output stq_out_t         res,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_ACK  = 3'd2;
    localparam logic [2:0] S_EXP  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_STOP = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [63:0] plen_reg, tick_reg, tick_next;
    stq_in_t     req_reg;
    logic        reject_reg, full_reg, any_reg;
    logic        res_valid_next;
    stq_out_t    res_next;
    stq_cmd_t    cmd;

    stq_entry_t  ents [NUM_TIMERS+1];
    logic        ins  [NUM_TIMERS+1];
    logic        rm   [NUM_TIMERS+1];

    assign ents[NUM_TIMERS] = '0;
    assign ins[0] = 1'b0;
    assign rm[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            stq_cell u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd),
                .prev_ent(g == 0 ? stq_entry_t'('0) : ents[(g == 0) ? 0 : g-1]),
                .prev_ins(ins[g]), .prev_rm(rm[g]),
                .next_ent(ents[g+1]),
                .ent(ents[g]), .ins_here(ins[g+1]), .rm_here(rm[g+1])
            );
        end
    endgenerate

    logic found, head_match, oneshot, accept;
    assign found      = rm[NUM_TIMERS];
    assign head_match = ents[0].valid && ents[0].id == req.timer_id;
    assign oneshot    = (mode_reg == MODE_ONESHOT);
    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        cmd            = '0;
        cmd.id         = req_reg.timer_id;
        cmd.len        = req_reg.length;
        cmd.action     = req_reg.action;
        res_valid_next = 1'b0;
        res_next       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.id = req.timer_id;
                    if (req.func == FUNC_START)
                    begin
                        if (req.length == 64'd0 || (!found && ents[NUM_TIMERS-1].valid))
                            state_next = S_ACK;
                        else
                        begin
                            cmd.remove = 1'b1;
                            state_next = S_INS;
                        end
                    end
                    else if (req.func == FUNC_STOP)
                    begin
                        res_valid_next = 1'b1;
                        res_next.timer_id_res = req.timer_id;
                        res_next.last = 1'b1;
                        if (head_match && ents[1 % (NUM_TIMERS+1)].valid && oneshot
                            && NUM_TIMERS > 1)
                        begin
                            res_next.prog_valid = 1'b1;
                            res_next.prog_len = ents[1 % (NUM_TIMERS+1)].rem;
                            tick_next = ents[1 % (NUM_TIMERS+1)].rem;
                        end
                        cmd.remove = 1'b1;
                        state_next = S_STOP;
                    end
                    else if (req.func == FUNC_TICK)
                    begin
                        cmd.sub = 1'b1;
                        cmd.len = tick_reg;
                        state_next = S_EXP;
                    end
                end
            end
            S_STOP:
                state_next = S_IDLE;
            S_INS:
            begin
                cmd.insert = 1'b1;
                state_next = S_ACK;
            end
            S_ACK:
            begin
                res_valid_next = 1'b1;
                res_next.timer_id_res = req_reg.timer_id;
                res_next.status = reject_reg;
                res_next.last = 1'b1;
                // Head changed when new entry sits at head or old head moved.
                if (!reject_reg && oneshot &&
                    ((ents[0].id == req_reg.timer_id && ents[0].rem == req_reg.length)
                     || full_reg))
                begin
                    res_next.prog_valid = 1'b1;
                    res_next.prog_len = ents[0].rem;
                    tick_next = ents[0].rem;
                end
                state_next = S_IDLE;
            end
            S_EXP:
            begin
                // After subtraction an expired entry wrapped or hit zero:
                // original remaining <= tick means rem - tick underflow or zero.
                if (ents[0].valid && ents[0].rem + tick_reg <= tick_reg)
                begin
                    res_valid_next = 1'b1;
                    res_next.event_res = EV_EXPIRED;
                    res_next.timer_id_res = ents[0].id;
                    res_next.expired_action = ents[0].action;
                    res_next.resched = (ents[0].action == ACT_RESCHED);
                    cmd.pop = 1'b1;
                end
                else
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                res_valid_next = 1'b1;
                res_next.event_res = EV_SUMMARY;
                res_next.resched = any_reg;
                res_next.last = 1'b1;
                if (ents[0].valid && oneshot)
                begin
                    res_next.prog_valid = 1'b1;
                    res_next.prog_len = ents[0].rem;
                    tick_next = ents[0].rem;
                end
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (cfg_we && mode_reg == MODE_PERIODIC && cfg_index == REG_PERIODIC_LEN)
            tick_next = cfg_data;
        else if (cfg_we && cfg_index == REG_CLOCK_MODE && cfg_data[1:0] == MODE_PERIODIC)
            tick_next = plen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_NONE;
            plen_reg  <= 64'd0;
            tick_reg  <= 64'd0;
            res_valid <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            res_valid <= res_valid_next;
            if (cfg_we && cfg_index == REG_CLOCK_MODE)
                mode_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == REG_PERIODIC_LEN)
                plen_reg <= cfg_data;
            if (accept)
                any_reg <= 1'b0;
            else if (res_valid_next && res_next.event_res == EV_EXPIRED)
                any_reg <= any_reg | res_next.resched;
        end
    end

    always_ff @(posedge clk)
    begin
        res <= res_next;
        if (accept)
        begin
            req_reg    <= req;
            reject_reg <= (req.length == 64'd0) || (!found && ents[NUM_TIMERS-1].valid);
            full_reg   <= head_match;
        end
    end
endmodule
`default_nettype wire

// ----- design/stq_cell.sv -----
`default_nettype none
module stq_cell
    import stq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stq_cmd_t   cmd,
    input  wire stq_entry_t prev_ent,  // neighbor toward head
    input  wire logic       prev_ins,  // key belongs at or before prev
    input  wire logic       prev_rm,   // match found at or before prev
    input  wire stq_entry_t next_ent,  // neighbor toward tail
    output stq_entry_t      ent,
    output logic            ins_here,
    output logic            rm_here
);
    stq_entry_t ent_reg, ent_next;
    logic       gt;

    // Key goes before this entry when entry is empty or strictly later.
    assign gt       = !ent_reg.valid || (ent_reg.rem > cmd.len);
    assign ins_here = prev_ins || gt;
    assign rm_here  = prev_rm || (ent_reg.valid && ent_reg.id == cmd.id);
    assign ent      = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.insert)
        begin
            if (prev_ins)
                ent_next = prev_ent;
            else if (gt)
                ent_next = '{valid: 1'b1, id: cmd.id, rem: cmd.len, action: cmd.action};
        end
        else if (cmd.remove || cmd.pop)
        begin
            if (cmd.pop || rm_here)
                ent_next = next_ent;
        end
        else if (cmd.sub)
        begin
            ent_next.rem = ent_reg.rem - cmd.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end
endmodule
`default_nettype wire

// ----- design/stq_checker.sv -----
`default_nettype none
module stq_props
    import stq_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire stq_in_t  req,
    input wire logic     busy,
    input wire logic     res_valid,
    input wire stq_out_t res
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.func == FUNC_START || req.func == FUNC_STOP
                           || req.func == FUNC_TICK) |=> busy)
        else $error("request not taken");
    a_more_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |-> busy) else $error("partial result while idle");
    a_exp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_res == EV_EXPIRED |-> !res.last)
        else $error("expired marked last");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !res_valid) else $error("stray result");
endmodule

bind sorted_timer_expiry_queue_top stq_props u_stq_props (
    .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
    .res_valid(res_valid), .res(res)
);
`default_nettype wire
